// ===== rtl/spid_pkg.sv =====
// ----------------------------------------------------------------------------
// spid_pkg
// Shared types and constants for the speed PID controller: register indexes,
// configuration bundle, field widths and reset values.
// ----------------------------------------------------------------------------
package spid_pkg;

  localparam int SPEED_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int SUM_W     = SPEED_W;

  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd3072;
  localparam logic [GAIN_W-1:0]  KI_RST    = 16'd486;
  localparam logic [GAIN_W-1:0]  KD_RST    = 16'd1280;
  localparam logic [LIMIT_W-1:0] ILIM_RST  = 15'd1000;
  localparam logic [LIMIT_W-1:0] THRESH_RST = 15'd400;
  localparam logic [LIMIT_W-1:0] KICK_RST  = 15'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_ILIM   = 3'd3,
    REG_THRESH = 3'd4,
    REG_KICK   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_gain;
    logic [GAIN_W-1:0]  ki_gain;
    logic [GAIN_W-1:0]  kd_gain;
    logic [LIMIT_W-1:0] integral_limit;
    logic [LIMIT_W-1:0] out_threshold;
    logic [LIMIT_W-1:0] out_kick;
  } cfg_t;

endpackage

// ===== rtl/spid_cfg.sv =====
// ----------------------------------------------------------------------------
// spid_cfg
// Configuration register bank: gains, integral clamp, threshold and kick.
// ----------------------------------------------------------------------------
module spid_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [spid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spid_pkg::CFG_W-1:0]   cfg_data,
  output spid_pkg::cfg_t               cfg
);
  import spid_pkg::*;

  cfg_t regs;
  cfg_t regs_next;

  always_comb begin
    regs_next = regs;
    if (cfg_we) begin
      case (cfg_index)
        REG_KP:     regs_next.kp_gain        = cfg_data;
        REG_KI:     regs_next.ki_gain        = cfg_data;
        REG_KD:     regs_next.kd_gain        = cfg_data;
        REG_ILIM:   regs_next.integral_limit = cfg_data[LIMIT_W-1:0];
        REG_THRESH: regs_next.out_threshold  = cfg_data[LIMIT_W-1:0];
        REG_KICK:   regs_next.out_kick       = cfg_data[LIMIT_W-1:0];
        default:    regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.kp_gain        <= KP_RST;
      regs.ki_gain        <= KI_RST;
      regs.kd_gain        <= KD_RST;
      regs.integral_limit <= ILIM_RST;
      regs.out_threshold  <= THRESH_RST;
      regs.out_kick       <= KICK_RST;
    end else begin
      regs <= regs_next;
    end
  end

  assign cfg = regs;

endmodule

// ===== rtl/speed_pid_with_clamps.sv =====
// ----------------------------------------------------------------------------
// speed_pid_with_clamps
// Positional PID speed controller with a clamped error sum and an output
// kick beyond a threshold.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         target_speed [15:0], measured_speed [31:16]
//  m_*       out        drive_value [15:0]
//  cfg_*     in         register write, index per reg_idx_t
//
//  One item per cycle sustained while the output is not stalled; a result
//  passes in order through the registered error/sum stage, multiply stage
//  and sum/scale/kick stage.
//  The error sum and last error update on the input transfer, a registered
//  add-and-clamp loop. Reset clears both and empties the pipeline.
//  Stages advance independently; a stalled output fills the earlier stages
//  before input ready drops.
// ----------------------------------------------------------------------------
module speed_pid_with_clamps #(
  parameter int GAIN_FRAC_BITS = spid_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // target_speed, measured_speed
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // drive_value
  input  logic                           cfg_we,
  input  logic [spid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spid_pkg::CFG_W-1:0]     cfg_data
);
  import spid_pkg::*;

  localparam int DIFF_W = ERR_W + 1;
  localparam int PP_W   = GAIN_W + 1 + ERR_W;
  localparam int PI_W   = GAIN_W + 1 + SUM_W;
  localparam int PD_W   = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W  = PD_W + 2;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  cfg_t cfg;

  spid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: each stage loads when empty or when it drains this cycle
  logic v1, v2, v3;
  logic go1, go2, go3;
  logic accept;

  assign go3      = !v3 || m_tready;
  assign go2      = !v2 || go3;
  assign go1      = !v1 || go2;
  assign s_tready = go1;
  assign accept   = s_tvalid && go1;
  assign m_tvalid = v3;

  // Stage 1: error, clamped sum, error change
  logic signed [SPEED_W-1:0] target_speed, measured_speed;
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  sum_raw, lim_pos, lim_neg, diff;
  logic signed [SUM_W-1:0]   sum_clamped;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   previous_error;

  assign target_speed   = s_tdata[15:0];
  assign measured_speed = s_tdata[31:16];

  always_comb begin
    err     = {target_speed[SPEED_W-1], target_speed}
            - {measured_speed[SPEED_W-1], measured_speed};
    sum_raw = {{(DIFF_W-SUM_W){error_sum[SUM_W-1]}}, error_sum}
            + {err[ERR_W-1], err};
    lim_pos = {{(DIFF_W-LIMIT_W){1'b0}}, cfg.integral_limit};
    lim_neg = -lim_pos;
    if (sum_raw >= lim_pos) begin
      sum_clamped = lim_pos[SUM_W-1:0];
    end else if (sum_raw <= lim_neg) begin
      sum_clamped = lim_neg[SUM_W-1:0];
    end else begin
      sum_clamped = sum_raw[SUM_W-1:0];
    end
    diff = {err[ERR_W-1], err} - {previous_error[ERR_W-1], previous_error};
  end

  logic signed [ERR_W-1:0]  s1_err;
  logic signed [SUM_W-1:0]  s1_sum;
  logic signed [DIFF_W-1:0] s1_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (accept) begin
      error_sum      <= sum_clamped;
      previous_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_err  <= err;
      s1_sum  <= sum_clamped;
      s1_diff <= diff;
    end
  end

  // Stage 2: three gain products
  logic signed [GAIN_W:0] kp_s, ki_s, kd_s;
  logic signed [PP_W-1:0] s2_pp;
  logic signed [PI_W-1:0] s2_pi;
  logic signed [PD_W-1:0] s2_pd;

  assign kp_s = {1'b0, cfg.kp_gain};
  assign ki_s = {1'b0, cfg.ki_gain};
  assign kd_s = {1'b0, cfg.kd_gain};

  always_ff @(posedge clk) begin
    if (go2) begin
      s2_pp <= kp_s * s1_err;
      s2_pi <= ki_s * s1_sum;
      s2_pd <= kd_s * s1_diff;
    end
  end

  // Stage 3: sum, scale toward zero, kick
  logic signed [ACC_W-1:0] acc, raw, thr_pos, thr_neg, kick_pos, kick_neg;
  logic [15:0]             drive;
  logic [15:0]             drive_value;

  always_comb begin
    acc = {{(ACC_W-PP_W){s2_pp[PP_W-1]}}, s2_pp}
        + {{(ACC_W-PI_W){s2_pi[PI_W-1]}}, s2_pi}
        + {{(ACC_W-PD_W){s2_pd[PD_W-1]}}, s2_pd};
    // bias negatives so the arithmetic shift truncates toward zero
    raw      = acc[ACC_W-1] ? ((acc + RND) >>> GAIN_FRAC_BITS)
                            : (acc >>> GAIN_FRAC_BITS);
    thr_pos  = {{(ACC_W-LIMIT_W){1'b0}}, cfg.out_threshold};
    thr_neg  = -thr_pos;
    kick_pos = {{(ACC_W-LIMIT_W){1'b0}}, cfg.out_kick};
    kick_neg = -kick_pos;
    if (raw > thr_pos) begin
      drive = kick_pos[15:0];
    end else if (raw < thr_neg) begin
      drive = kick_neg[15:0];
    end else begin
      drive = raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      drive_value <= drive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (go1) v1 <= s_tvalid;
      if (go2) v2 <= v1;
      if (go3) v3 <= v2;
    end
  end

  assign m_tdata = drive_value;

endmodule

// ===== verif/tb_speed_pid_with_clamps.sv =====
// ----------------------------------------------------------------------------
// tb_speed_pid_with_clamps
// Self-checking bench for the speed PID controller. Speed pairs are streamed
// in with random gaps and output back-pressure. Each transfer runs through an
// in-bench controller model that keeps its own error sum, last error and
// register copy. Every drive value is checked in order. The bench steps
// through several register settings, including the all-zero and all-maximum
// extremes.
// ----------------------------------------------------------------------------
module tb_speed_pid_with_clamps;
  import spid_pkg::*;

  localparam int FRAC        = GAIN_FRAC_BITS_DEF;
  localparam int DRAIN_WAIT  = 6;
  localparam int STALL_LEN   = 64;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_ITEMS = 235;

  typedef struct packed {
    logic signed [15:0] measured;
    logic signed [15:0] target;
  } speed_pair_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // target_speed, measured_speed
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;        // drive_value
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  speed_pair_t        speed_queue[$];
  logic signed [15:0] drive_expected[$];
  logic               in_fire = 1'b0;
  int                 idle_pct = 16;
  int                 stall_ask = 0;
  int                 stall_seen = 0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;
  int                 errors = 0;
  logic signed [15:0] drive_want;

  // controller model state and register copy
  logic [15:0]        kp_q, ki_q, kd_q;
  logic [14:0]        lim_q, thr_q, kick_q;
  logic signed [15:0] sum_q;
  logic signed [16:0] prev_err_q;

  speed_pid_with_clamps dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [15:0] predict_drive(speed_pair_t item);
    int                 err;
    int                 sum;
    int                 lim;
    int                 thr;
    longint             acc;
    longint             raw;
    logic signed [15:0] drive;
    err = int'($signed(item.target)) - int'($signed(item.measured));
    lim = int'(lim_q);
    thr = int'(thr_q);
    // clamp after the add, so a sum equal to the limit is kept
    sum = int'(sum_q) + err;
    if (sum >= lim) begin
      sum = lim;
    end else if (sum <= -lim) begin
      sum = -lim;
    end
    sum_q = sum[15:0];
    acc = longint'(kp_q) * err + longint'(ki_q) * sum
        + longint'(kd_q) * (err - int'(prev_err_q));
    // signed division truncates toward zero
    raw = acc / (longint'(1) << FRAC);
    prev_err_q = err[16:0];
    if (raw > thr) begin
      drive = 16'(kick_q);
    end else if (raw < -thr) begin
      drive = 16'(-int'(kick_q));
    end else begin
      drive = raw[15:0];
    end
    return drive;
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_KP:     kp_q   = value;
      REG_KI:     ki_q   = value;
      REG_KD:     kd_q   = value;
      REG_ILIM:   lim_q  = value[14:0];
      REG_THRESH: thr_q  = value[14:0];
      REG_KICK:   kick_q = value[14:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                             logic [15:0] lim, logic [15:0] thr, logic [15:0] kick);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_ILIM, lim);
    write_reg(REG_THRESH, thr);
    write_reg(REG_KICK, kick);
    end_writes();
  endtask

  function automatic logic [15:0] random_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 512));
      1: return 16'($urandom_range(0, 4096));
      2: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] random_mag();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 1000))
                                : 16'($urandom_range(0, 32767));
  endfunction

  task automatic add_pair(int target, int measured);
    speed_pair_t p;
    p.target   = target[15:0];
    p.measured = measured[15:0];
    speed_queue.push_back(p);
  endtask

  task automatic add_random_pairs(int n);
    speed_pair_t p;
    int          t;
    for (int i = 0; i < n; i++) begin
      p = speed_pair_t'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        9: begin
          p.target   = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          p.measured = $urandom_range(0, 2) == 0 ? 16'sh0000
                     : ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000);
        end
        default: begin
          // track near the measured speed so the loop stays off the kick
          t = int'($signed(p.measured)) + int'($urandom_range(0, 600)) - 300;
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          p.target = t[15:0];
        end
      endcase
      speed_queue.push_back(p);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (speed_queue.size() != 0 || s_tvalid || drive_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (speed_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= speed_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (stall_ask != stall_seen) begin
      stall_seen = stall_ask;
      stall_left = STALL_LEN;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    in_fire <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        drive_expected.push_back(predict_drive(speed_pair_t'(s_tdata)));
      end
      if (m_tvalid && m_tready) begin
        if (drive_expected.size() == 0) begin
          note_error($sformatf("unexpected drive_value %0d", $signed(m_tdata)));
        end else begin
          drive_want = drive_expected.pop_front();
          if (m_tdata !== drive_want) begin
            note_error($sformatf("drive_value mismatch: expected %0d got %0d",
                                 drive_want, $signed(m_tdata)));
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    kp_q       = KP_RST;
    ki_q       = KI_RST;
    kd_q       = KD_RST;
    lim_q      = ILIM_RST;
    thr_q      = THRESH_RST;
    kick_q     = KICK_RST;
    sum_q      = '0;
    prev_err_q = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, full-range errors and the integral clamp
    program_all(KP_RST, KI_RST, KD_RST, 16'(ILIM_RST), 16'(THRESH_RST), 16'(KICK_RST));
    add_pair(0, 0);
    add_pair(32767, -32768);
    add_pair(-32768, 32767);
    add_pair(100, 100);
    add_pair(-1, 0);
    add_pair(1, 0);
    add_pair(500, 0);
    add_pair(500, 0);
    add_pair(600, 0);
    add_pair(-3000, 0);
    wait_drained();

    // unity proportional gain: raw equals the error, probe the threshold edges
    program_all(16'd256, 16'd0, 16'd0, 16'd1000, 16'd400, 16'd600);
    add_pair(400, 0);
    add_pair(401, 0);
    add_pair(0, 400);
    add_pair(0, 401);
    add_pair(0, 0);
    wait_drained();

    // zero limit and zero threshold: every nonzero output kicks
    program_all(16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 16'd777);
    add_pair(1, 0);
    add_pair(-1, 0);
    add_pair(0, 0);
    add_pair(0, 0);
    wait_drained();

    // everything at its maximum, then lower the limit under a full sum
    program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd32767, 16'd32767, 16'd32767);
    add_pair(32767, -32768);
    add_pair(32767, -32768);
    add_pair(-32768, 32767);
    add_pair(32767, -32768);
    wait_drained();
    write_reg(REG_ILIM, 16'd50);
    end_writes();
    add_pair(0, 0);
    add_pair(3, 0);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: program_all(KP_RST, KI_RST, KD_RST,
                       16'(ILIM_RST), 16'(THRESH_RST), 16'(KICK_RST));
        1: program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd32767, 16'd32767, 16'd32767);
        2: program_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default: program_all(random_gain(), random_gain(), random_gain(),
                             random_mag(), random_mag(), random_mag());
      endcase
      idle_pct = (phase == 3) ? 0 : 16;
      // hold the output off while the input keeps offering
      if (phase == 5) stall_ask++;
      add_random_pairs(PHASE_ITEMS);
      wait_drained();
    end

    errors += drive_expected.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/spid_pkg.sv
rtl/spid_cfg.sv
rtl/speed_pid_with_clamps.sv
verif/tb_speed_pid_with_clamps.sv
